### hw/rtl/ktz_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the k-times zoom interpolator.
// No dependencies; imported by every module of the block.
package ktz_pkg;

    localparam int ZOOM_W = 5;
    localparam logic [ZOOM_W-1:0] ZOOM_RESET = 5'd2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_LAST = 4'b1000
    } state_t;

endpackage

### hw/rtl/ktz_div.sv
`timescale 1ns / 1ps
// Restoring divider that reuses one subtract-and-compare unit, one quotient bit a cycle.
// Depends on ktz_pkg.
module ktz_div #(
    parameter int DIVIDEND_W = 8,
    parameter int DIVISOR_W  = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);
    import ktz_pkg::*;

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic [DIVIDEND_W-1:0] q_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // Shift the next dividend bit into the partial remainder and try the subtract.
    assign trial = {rem_reg, q_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = (trial >= {1'b0, div_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIVIDEND_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

### hw/rtl/k_times_zoom_interpolator.sv
`timescale 1ns / 1ps
// Top level of the k-times zoom interpolator: sequencer, pixel state and output register.
// Depends on ktz_pkg and ktz_div.
//
//  channel   | direction | tdata                 | tlast        | tuser
//  ----------+-----------+-----------------------+--------------+---------
//  s_        | in        | pixel_value           | line_end     | -
//  m_        | out       | out_pixel             | out_line_end | run_last
//  cfg_      | in        | zoom_factor (write only, no index)
//
// A pixel that closes a neighbor pair is accepted, divided in the divider, has its step
// loaded, then gives k output transactions. The first pixel of a line is only stored
// unless it also ends the line; a line-end pixel adds one output transaction.
// The output register lets the next pixel be accepted while the last result waits.
// A stall on m_tready holds the emit and last states; reset is synchronous and active low.
module k_times_zoom_interpolator #(
    parameter int PIXEL_BITS = 8,
    parameter int MAX_ZOOM   = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]      s_tdata,   // [PIXEL_BITS-1:0] pixel_value
    input  logic                                 s_tlast,   // line_end
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((PIXEL_BITS+7)/8)*8-1:0]      m_tdata,   // [PIXEL_BITS-1:0] out_pixel
    output logic                                 m_tlast,   // out_line_end
    output logic                                 m_tuser,   // run_last
    input  logic                                 cfg_we,
    input  logic [ktz_pkg::ZOOM_W-1:0]           cfg_wdata  // zoom_factor
);
    import ktz_pkg::*;

    localparam int DATA_W = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int K_W    = $clog2(MAX_ZOOM + 1);
    localparam int CMP_W  = (K_W > ZOOM_W) ? K_W : ZOOM_W;

    state_t state_reg, state_next;

    logic [ZOOM_W-1:0]     zoom_reg;
    logic [PIXEL_BITS-1:0] prev_reg;
    logic                  have_prev_reg;
    logic [PIXEL_BITS-1:0] cur_reg;
    logic                  eol_reg;
    logic                  rising_reg;
    logic [K_W-1:0]        k_reg;
    logic [K_W-1:0]        n_reg;
    logic [PIXEL_BITS-1:0] val_reg;
    logic [PIXEL_BITS-1:0] step_reg;

    logic                  m_valid_reg;
    logic [PIXEL_BITS-1:0] m_pix_reg;
    logic                  m_eol_reg;
    logic                  m_run_reg;

    logic [PIXEL_BITS-1:0] in_pix;
    logic                  in_accept;
    logic                  in_rising;
    logic [PIXEL_BITS-1:0] in_diff;
    logic [CMP_W-1:0]      zoom_ext;
    logic [K_W-1:0]        k_eff;
    logic                  slot_free;
    logic                  emit_load;
    logic                  last_load;
    logic                  run_end;
    logic                  div_busy;
    logic                  div_done;
    logic [PIXEL_BITS-1:0] div_quot;

    assign in_pix    = s_tdata[PIXEL_BITS-1:0];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_rising = (prev_reg < in_pix);
    assign in_diff   = in_rising ? (in_pix - prev_reg) : (prev_reg - in_pix);

    // Zero acts as one, and anything above the maximum is clipped to it.
    assign zoom_ext = CMP_W'(zoom_reg);
    always_comb begin
        if (zoom_ext == '0) begin
            k_eff = K_W'(1);
        end else if (zoom_ext > CMP_W'(MAX_ZOOM)) begin
            k_eff = K_W'(MAX_ZOOM);
        end else begin
            k_eff = K_W'(zoom_ext);
        end
    end

    ktz_div #(
        .DIVIDEND_W (PIXEL_BITS),
        .DIVISOR_W  (K_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (in_accept && have_prev_reg),
        .dividend (in_diff),
        .divisor  (k_eff),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign slot_free = !m_valid_reg || m_tready;
    assign emit_load = (state_reg == ST_EMIT) && slot_free;
    assign last_load = (state_reg == ST_LAST) && slot_free;
    assign run_end   = (n_reg == k_reg - 1'b1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (have_prev_reg) begin
                        state_next = ST_DIV;
                    end else if (s_tlast) begin
                        state_next = ST_LAST;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_load && run_end) begin
                    state_next = eol_reg ? ST_LAST : ST_IDLE;
                end
            end
            ST_LAST: begin
                if (last_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            zoom_reg      <= ZOOM_RESET;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                zoom_reg <= cfg_wdata;
            end
            if (in_accept) begin
                prev_reg      <= in_pix;
                have_prev_reg <= !s_tlast;
            end
            if (emit_load || last_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            cur_reg    <= in_pix;
            eol_reg    <= s_tlast;
            rising_reg <= in_rising;
            k_reg      <= k_eff;
            val_reg    <= prev_reg;
        end
        if (div_done) begin
            step_reg <= div_quot;
            n_reg    <= '0;
        end
        if (emit_load) begin
            val_reg <= rising_reg ? (val_reg + step_reg) : (val_reg - step_reg);
            n_reg   <= n_reg + 1'b1;
            m_pix_reg <= val_reg;
            m_eol_reg <= 1'b0;
            m_run_reg <= !eol_reg && run_end;
        end else if (last_load) begin
            m_pix_reg <= cur_reg;
            m_eol_reg <= 1'b1;
            m_run_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DATA_W'(m_pix_reg);
    assign m_tlast  = m_eol_reg;
    assign m_tuser  = m_run_reg;

    // A pixel that closes a pair must start the divider.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && have_prev_reg |=> state_reg == ST_DIV)
        else $error("pair pixel did not start the divide");

    // The divider only runs while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (div_busy || div_done) |-> state_reg == ST_DIV)
        else $error("divider active outside the divide state");

    // The run counter never passes the zoom factor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> n_reg < k_reg)
        else $error("run counter out of range");

    // A result is never overwritten while it is stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |-> !emit_load && !last_load)
        else $error("output register overwritten during stall");

endmodule
